// ===== hdl/kce_pkg.sv =====
// shared types and constants for the k-combination enumerator
// no dependencies; imported by kce_csr, kce_seq and the top level
package kce_pkg;

   localparam int CNT_W  = 6;   // position counter width
   localparam int ELEM_W = 8;   // set element width
   localparam int POS_W  = 3;   // position-in-subset width
   localparam int K_W    = 4;   // hand_size register width
   localparam int N_W    = 7;   // set_size register width
   localparam int SLOT_W = 6;   // load slot width

   typedef logic [1:0] op_type;
   localparam op_type OP_LOAD    = 2'd0;
   localparam op_type OP_RESTART = 2'd1;
   localparam op_type OP_NEXT    = 2'd2;

   // register index as decoded from paddr[2]
   localparam logic REG_HAND_SIZE = 1'b0;
   localparam logic REG_SET_SIZE  = 1'b1;

   typedef struct packed {
      logic [K_W-1:0] hand_size;
      logic [N_W-1:0] set_size;
   } cfg_type;

   // one store read issued by the sequencer, with the result tags it carries
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] position;
      logic             last_of_subset;
      logic             final_subset;
      logic             exhausted;
      logic             zero_element;
   } issue_type;

endpackage

// ===== hdl/kce_ram.sv =====
// generic single-port-write, single-port-read ram with registered read
// no dependencies; read data holds while the read enable is low
module kce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/kce_csr.sv =====
// configuration registers (hand_size, set_size) behind an apb-style port
// depends on kce_pkg
module kce_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_psel,
   input  logic             csr_penable,
   input  logic             csr_pwrite,
   input  logic [2:0]       csr_paddr,
   input  logic [31:0]      csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output kce_pkg::cfg_type cfg
);
   import kce_pkg::*;

   logic [K_W-1:0] hand_size_ff, hand_size_in;
   logic [N_W-1:0] set_size_ff, set_size_in;
   logic           wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   always_comb begin
      hand_size_in = hand_size_ff;
      set_size_in  = set_size_ff;
      if (wr_en) begin
         unique case (csr_paddr[2])
            REG_HAND_SIZE: hand_size_in = csr_pwdata[K_W-1:0];
            REG_SET_SIZE:  set_size_in  = csr_pwdata[N_W-1:0];
            default:       ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hand_size_ff <= K_W'(3);
         set_size_ff  <= N_W'(40);
      end else begin
         hand_size_ff <= hand_size_in;
         set_size_ff  <= set_size_in;
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         REG_HAND_SIZE: csr_prdata = 32'(hand_size_ff);
         REG_SET_SIZE:  csr_prdata = 32'(set_size_ff);
         default:       csr_prdata = '0;
      endcase
   end

   assign cfg.hand_size = hand_size_ff;
   assign cfg.set_size  = set_size_ff;

endmodule

// ===== hdl/kce_seq.sv =====
// sequencer: decodes transactions, holds the position counters, issues one
// store read per subset element and advances the enumeration; depends on kce_pkg
module kce_seq #(
   parameter int MAX_SET = 64,
   parameter int MAX_K   = 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  kce_pkg::op_type            req_op,
   input  logic [kce_pkg::SLOT_W-1:0] req_slot,
   input  logic [kce_pkg::ELEM_W-1:0] req_value,
   input  kce_pkg::cfg_type           cfg,
   input  logic                       s1_free,
   output logic                       ram_we,
   output logic [$clog2(MAX_SET)-1:0] ram_waddr,
   output logic [kce_pkg::ELEM_W-1:0] ram_wdata,
   output logic                       ram_re,
   output logic [$clog2(MAX_SET)-1:0] ram_raddr,
   output kce_pkg::issue_type         issue
);
   import kce_pkg::*;

   localparam int         AW        = $clog2(MAX_SET);
   localparam int         KW        = (MAX_K > 1) ? $clog2(MAX_K) : 1;
   localparam logic [8:0] MAX_SET_W = 9'(MAX_SET);
   localparam logic [4:0] MAX_K_W   = 5'(MAX_K);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EMIT = 3'b010,
      ST_EXH  = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff [MAX_K];
   logic [CNT_W-1:0] cnt_in [MAX_K];
   logic             needs_init_ff, needs_init_in;
   logic             done_ff, done_in;
   logic [KW-1:0]    j_ff, j_in;
   logic             found_ff, found_in;
   logic [KW-1:0]    p_ff, p_in;
   logic [CNT_W-1:0] cv_ff, cv_in;

   logic             accept;
   logic [K_W-1:0]   k;
   logic [N_W-1:0]   n_sat;
   logic [N_W-1:0]   nk;
   logic             illegal;
   logic [CNT_W-1:0] cur;
   logic [8:0]       cur_wide;
   logic [8:0]       slot_wide;
   logic [7:0]       limit;
   logic             below;
   logic             fin;
   logic             last;
   logic             found_now;
   logic [KW-1:0]    p_now;
   logic [CNT_W-1:0] cv_now;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid & req_ready;

   assign k       = cfg.hand_size;
   assign n_sat   = ({2'b0, cfg.set_size} > MAX_SET_W) ? MAX_SET_W[N_W-1:0] : cfg.set_size;
   assign illegal = (k == '0) || (5'(k) > MAX_K_W) || (N_W'(k) > n_sat);
   assign nk      = n_sat - N_W'(k);

   // current counter and its advance test
   assign cur       = cnt_ff[j_ff];
   assign cur_wide  = 9'(cur);
   assign limit     = 8'(nk) + 8'(j_ff);
   assign below     = 8'(cur) < limit;
   assign fin       = N_W'(cnt_ff[0]) >= nk;
   assign last      = 5'(j_ff) == (5'(k) - 5'd1);
   assign found_now = below | found_ff;
   assign p_now     = below ? j_ff : p_ff;
   assign cv_now    = below ? cur : cv_ff;

   // store writes from load transactions
   assign slot_wide = 9'(req_slot);
   assign ram_we    = accept && (req_op == OP_LOAD) && (slot_wide < MAX_SET_W);
   assign ram_waddr = slot_wide[AW-1:0];
   assign ram_wdata = req_value;

   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      needs_init_in = needs_init_ff;
      done_in       = done_ff;
      j_in          = j_ff;
      found_in      = found_ff;
      p_in          = p_ff;
      cv_in         = cv_ff;
      ram_re        = 1'b0;
      ram_raddr     = cur_wide[AW-1:0];
      issue         = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               j_in     = '0;
               found_in = 1'b0;
               case (req_op)
                  OP_RESTART: begin
                     needs_init_in = 1'b1;
                     done_in       = 1'b0;
                  end
                  OP_NEXT: begin
                     if (illegal) begin
                        state_in = ST_EXH;
                     end else if (needs_init_ff) begin
                        for (int i = 0; i < MAX_K; i++) begin
                           if (5'(i) < 5'(k)) begin
                              cnt_in[i] = CNT_W'(i);
                           end
                        end
                        needs_init_in = 1'b0;
                        done_in       = 1'b0;
                        state_in      = ST_EMIT;
                     end else if (done_ff) begin
                        state_in = ST_EXH;
                     end else begin
                        state_in = ST_EMIT;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_EMIT: begin
            if (s1_free) begin
               ram_re               = 1'b1;
               issue.valid          = 1'b1;
               issue.position       = POS_W'(j_ff);
               issue.last_of_subset = last;
               issue.final_subset   = fin;
               issue.zero_element   = cur_wide >= MAX_SET_W;
               found_in             = found_now;
               p_in                 = p_now;
               cv_in                = cv_now;
               if (last) begin
                  state_in = ST_IDLE;
                  if (fin || !found_now) begin
                     done_in = 1'b1;
                  end else begin
                     // bump the rightmost movable counter, refill the rest in a row
                     for (int i = 0; i < MAX_K; i++) begin
                        if ((5'(i) >= 5'(p_now)) && (5'(i) < 5'(k))) begin
                           cnt_in[i] = cv_now + CNT_W'(i) - CNT_W'(p_now) + CNT_W'(1);
                        end
                     end
                  end
               end else begin
                  j_in = j_ff + KW'(1);
               end
            end
         end
         ST_EXH: begin
            if (s1_free) begin
               issue.valid        = 1'b1;
               issue.exhausted    = 1'b1;
               issue.zero_element = 1'b1;
               state_in           = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         needs_init_ff <= 1'b1;
         done_ff       <= 1'b0;
         j_ff          <= '0;
         found_ff      <= 1'b0;
         for (int i = 0; i < MAX_K; i++) begin
            cnt_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         needs_init_ff <= needs_init_in;
         done_ff       <= done_in;
         j_ff          <= j_in;
         found_ff      <= found_in;
         cnt_ff        <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff  <= p_in;
      cv_ff <= cv_in;
   end

endmodule

// ===== hdl/k_combination_enumerator_unit.sv =====
// top level of the k-combination enumerator
// depends on kce_pkg, kce_ram, kce_csr, kce_seq
//
// usage
//   req channel: one transaction per command; tuser carries the operation
//     (load, restart, next), tdata the slot and element value of a load
//   rsp channel: one transaction per subset element, tlast on the k-th one;
//     tuser flags the final subset and the exhausted report
//   csr port: hand_size at address 0, set_size at address 4, written while idle
// timing
//   load and restart complete in their accept cycle; an exhausted report holds
//     the request side through the exhaust state; a next command holds it for
//     the accept and k store reads through the single read port, which wait
//     while the read stage is full; each element passes the read stage and
//     the output register before it is offered; a new command is taken as soon
//     as the last store read of the previous one is issued, while results still drain
// reset
//   clears the counters, arms the rewind to 0..k-1, clears the done mark and
//   loads hand_size 3, set_size 40; the set store is not cleared
// stall
//   with rsp_tready low the output register holds, one more element waits in
//   the read stage, and issue of further store reads stops until space frees
module k_combination_enumerator_unit #(
   parameter int MAX_SET = 64,
   parameter int MAX_K   = 8
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,    // slot[5:0], element_value[13:6], zero pad
   input  logic [1:0]  req_tuser,    // operation[1:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // element[7:0], position[10:8], zero pad
   output logic        rsp_tlast,
   output logic [1:0]  rsp_tuser,    // final_subset[0], exhausted[1]
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import kce_pkg::*;

   localparam int AW = $clog2(MAX_SET);

   cfg_type           cfg;
   issue_type         issue;
   logic              s1_free;
   logic              ram_we;
   logic [AW-1:0]     ram_waddr;
   logic [ELEM_W-1:0] ram_wdata;
   logic              ram_re;
   logic [AW-1:0]     ram_raddr;
   logic [ELEM_W-1:0] ram_rdata;

   // read stage: tags for the store read in flight
   logic              s1_valid_ff, s1_valid_in;
   issue_type         s1_meta_ff;

   // output register
   logic              out_valid_ff, out_valid_in;
   logic [ELEM_W-1:0] out_element_ff;
   logic [POS_W-1:0]  out_position_ff;
   logic              out_last_ff;
   logic              out_final_ff;
   logic              out_exh_ff;
   logic              out_load;

   kce_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   kce_seq #(
      .MAX_SET (MAX_SET),
      .MAX_K   (MAX_K)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_op    (req_tuser),
      .req_slot  (req_tdata[SLOT_W-1:0]),
      .req_value (req_tdata[SLOT_W+ELEM_W-1:SLOT_W]),
      .cfg       (cfg),
      .s1_free   (s1_free),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .issue     (issue)
   );

   // set store, read data holds while the read stage is stalled
   kce_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (MAX_SET)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // move the read stage into the output register when it is empty or draining
   assign out_load = s1_valid_ff & (~out_valid_ff | rsp_tready);
   assign s1_free  = ~s1_valid_ff | out_load;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (issue.valid) begin
         s1_valid_in = 1'b1;
      end else if (out_load) begin
         s1_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (issue.valid) begin
         s1_meta_ff <= issue;
      end
      if (out_load) begin
         // counters beyond the store and exhausted reports give element zero
         out_element_ff  <= s1_meta_ff.zero_element ? '0 : ram_rdata;
         out_position_ff <= s1_meta_ff.position;
         out_last_ff     <= s1_meta_ff.last_of_subset;
         out_final_ff    <= s1_meta_ff.final_subset;
         out_exh_ff      <= s1_meta_ff.exhausted;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {5'b0, out_position_ff, out_element_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = {out_exh_ff, out_final_ff};

endmodule

// ===== bench/tb_k_combination_enumerator_unit.sv =====
`timescale 1ns / 100ps
// self-checking bench for k_combination_enumerator_unit: streams load, restart and next
// commands, predicts every subset element in step with accepted commands
// depends on kce_pkg and the block's rtl only
module tb_k_combination_enumerator_unit;
   import kce_pkg::*;

   localparam int SET_DEPTH        = 64;
   localparam int K_LIMIT          = 8;
   localparam op_type OP_UNUSED    = 2'd3;
   localparam logic [2:0] ADDR_HAND_SIZE = {REG_HAND_SIZE, 2'b00};
   localparam logic [2:0] ADDR_SET_SIZE  = {REG_SET_SIZE, 2'b00};
   localparam int SETTLE_CYCLES    = 16;    // slack before a configuration write
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int HOLD_AT_CMD      = 180;
   localparam int WATCHDOG_LIMIT   = 3000;

   // one pending command for the request channel
   typedef struct {
      op_type           op;
      logic [SLOT_W-1:0] slot;
      logic [ELEM_W-1:0] value;
      bit               drain_first;   // sender waits for every result before offering it
   } cmd_item_type;

   // one subset element as it leaves the result channel
   typedef struct packed {
      logic [ELEM_W-1:0] element;
      logic [POS_W-1:0]  position;
      logic              last_of_subset;
      logic              final_subset;
      logic              exhausted;
   } subset_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;    // slot[5:0], element_value[13:6], zero pad
   logic [1:0]  req_tuser = '0;    // operation[1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // element[7:0], position[10:8], zero pad
   logic        rsp_tlast;
   logic [1:0]  rsp_tuser;         // final_subset[0], exhausted[1]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   k_combination_enumerator_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------------------
   // predictor state: own copy of the store, the walk counters and the registers
   // ---------------------------------------------------------------------------
   logic [ELEM_W-1:0] set_copy [SET_DEPTH];
   logic [CNT_W-1:0]  walk_pos [K_LIMIT];
   bit                rewind_armed = 1'b1;
   bit                walk_done = 1'b0;
   logic [K_W-1:0]    hand_k = 4'd3;
   logic [N_W-1:0]    set_n = 7'd40;

   cmd_item_type    cmd_queue [$];    // commands not yet offered
   subset_elem_type elem_expect [$];  // subset elements still owed by the block

   int  results_due = 0;     // elements predicted so far
   int  results_seen = 0;    // elements taken from the result channel
   int  accepted_cmds = 0;
   int  errors = 0;
   bit  calm = 1'b0;         // no idling on either side while set

   // appends one owed element at the tail of the expectation queue
   function automatic void owe_elem(subset_elem_type e);
      elem_expect.insert(elem_expect.size(), e);
   endfunction

   function automatic void owe_exhausted();
      subset_elem_type e;
      e = '0;
      e.exhausted = 1'b1;
      owe_elem(e);
   endfunction

   // applies one accepted command, queues the elements it causes and returns their count
   function automatic int step_enumerator(cmd_item_type c);
      int k, n, j, p;
      bit is_last, found;
      subset_elem_type e;
      k = hand_k;
      n = set_n;
      case (c.op)
         OP_LOAD: begin
            set_copy[c.slot] = c.value;
            return 0;
         end
         OP_RESTART: begin
            rewind_armed = 1'b1;
            walk_done = 1'b0;
            return 0;
         end
         OP_NEXT: begin
            if (n > SET_DEPTH) n = SET_DEPTH;   // oversized set_size saturates
            // illegal or oversized k reports exhausted without touching the walk
            if (k == 0 || k > K_LIMIT || k > n) begin
               owe_exhausted();
               return 1;
            end
            if (rewind_armed) begin
               for (j = 0; j < k; j++) walk_pos[j] = CNT_W'(j);
               rewind_armed = 1'b0;
               walk_done = 1'b0;
            end
            if (walk_done) begin
               owe_exhausted();
               return 1;
            end
            // last subset is spotted from the first counter alone
            is_last = int'(walk_pos[0]) >= n - k;
            for (j = 0; j < k; j++) begin
               e.element        = set_copy[walk_pos[j]];
               e.position       = POS_W'(j);
               e.last_of_subset = (j == k - 1);
               e.final_subset   = is_last;
               e.exhausted      = 1'b0;
               owe_elem(e);
            end
            if (is_last) begin
               walk_done = 1'b1;
            end else begin
               // bump the rightmost counter below its limit, refill to its right
               found = 1'b0;
               for (p = k - 1; p >= 0; p--) begin
                  if (int'(walk_pos[p]) < n - k + p) begin
                     found = 1'b1;
                     break;
                  end
               end
               if (!found) begin
                  walk_done = 1'b1;
               end else begin
                  walk_pos[p] = walk_pos[p] + CNT_W'(1);
                  for (j = p + 1; j < k; j++) walk_pos[j] = walk_pos[j-1] + CNT_W'(1);
               end
            end
            return k;
         end
         default: return 0;   // unused code is dropped by the block
      endcase
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------------
   // request driver: offers queued commands, predicts each one on its transaction
   // ---------------------------------------------------------------------------
   cmd_item_type cur_cmd;
   int           send_gap = 0;
   int           due_now;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap = 0;
      end else begin
         due_now = results_due;
         if (req_tvalid && req_tready) begin
            due_now = due_now + step_enumerator(cur_cmd);
            results_due <= due_now;
            accepted_cmds <= accepted_cmds + 1;
            send_gap = pick_gap();
         end
         // an offered transaction stays put until the block takes it
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (cmd_queue.size() != 0 &&
                         !(cmd_queue[0].drain_first && results_seen < due_now)) begin
               cur_cmd = cmd_queue.pop_front();
               req_tuser <= cur_cmd.op;
               req_tdata <= {2'b00, cur_cmd.value, cur_cmd.slot};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // result side: ready pattern in its own process, including one long hold-off
   // that backs the block up into its request channel
   // ---------------------------------------------------------------------------
   int ready_wait = 0;
   int long_hold_left = 0;
   bit long_hold_done = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_wait = 0;
      end else if (long_hold_left > 0) begin
         long_hold_left--;
         rsp_tready <= 1'b0;
      end else if (!long_hold_done && accepted_cmds >= HOLD_AT_CMD) begin
         long_hold_done = 1'b1;
         long_hold_left = LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (ready_wait > 0) begin
         ready_wait--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         ready_wait = pick_gap();
      end
   end

   // monitor: every result transaction is checked against the oldest owed element
   subset_elem_type got_elem, want_elem;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_elem.element        = rsp_tdata[ELEM_W-1:0];
         got_elem.position       = rsp_tdata[ELEM_W+POS_W-1:ELEM_W];
         got_elem.last_of_subset = rsp_tlast;
         got_elem.final_subset   = rsp_tuser[0];
         got_elem.exhausted      = rsp_tuser[1];
         results_seen <= results_seen + 1;
         if (elem_expect.size() == 0) begin
            $display("%0t unexpected rsp transaction: el=%0d pos=%0d last=%b fin=%b exh=%b",
                     $time, got_elem.element, got_elem.position, got_elem.last_of_subset,
                     got_elem.final_subset, got_elem.exhausted);
            errors++;
         end else begin
            want_elem = elem_expect.pop_front();
            if (got_elem !== want_elem) begin
               $display("%0t rsp mismatch: expected el=%0d pos=%0d last=%b fin=%b exh=%b",
                        $time, want_elem.element, want_elem.position,
                        want_elem.last_of_subset, want_elem.final_subset,
                        want_elem.exhausted);
               $display("%0t                 actual el=%0d pos=%0d last=%b fin=%b exh=%b",
                        $time, got_elem.element, got_elem.position, got_elem.last_of_subset,
                        got_elem.final_subset, got_elem.exhausted);
               errors++;
            end
         end
      end
   end

   // watchdog: too long without any transaction on either channel ends the run
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t watchdog: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------------------
   function automatic void queue_cmd(op_type op, logic [SLOT_W-1:0] slot,
                                     logic [ELEM_W-1:0] value, bit drain_first);
      cmd_item_type c;
      c.op = op;
      c.slot = slot;
      c.value = value;
      c.drain_first = drain_first;
      cmd_queue.insert(cmd_queue.size(), c);
   endfunction

   // block idle: every command taken, every element back, then the pipeline tail;
   // checked at the falling edge, once the rising-edge updates have landed
   task automatic settle();
      do @(negedge clock);
      while (cmd_queue.size() != 0 || req_tvalid || results_seen < results_due);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      @(posedge clock);
      csr_psel   <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_paddr  <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (addr == ADDR_HAND_SIZE) hand_k = data[K_W-1:0];
      else set_n = data[N_W-1:0];
   endtask

   task automatic set_config(input int k, input int n);
      settle();
      csr_write(ADDR_HAND_SIZE, k);
      csr_write(ADDR_SET_SIZE, n);
   endtask

   // ---------------------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------------------
   initial begin
      int s, i, k, n, r, ph;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // fill the whole store first so that no walk ever reads an unwritten entry;
      // slot 0 and slot 63 carry the value extremes
      for (s = 0; s < SET_DEPTH; s++)
         queue_cmd(OP_LOAD, SLOT_W'(s), (s == 0) ? 8'h00 : (s == SET_DEPTH - 1) ? 8'hFF
                                             : 8'($urandom_range(0, 255)), 1'b0);
      // first next after reset rewinds with the reset-time k and n
      queue_cmd(OP_NEXT, '0, '0, 1'b0);

      // full walk of 3 out of 5, then one past the end
      set_config(3, 5);
      queue_cmd(OP_RESTART, '0, '0, 1'b0);
      for (i = 0; i < 11; i++) queue_cmd(OP_NEXT, '0, '0, 1'b0);
      queue_cmd(OP_UNUSED, 6'h3F, 8'hFF, 1'b0);      // dropped without a result
      queue_cmd(OP_LOAD, 6'h3F, 8'hFF, 1'b0);
      queue_cmd(OP_LOAD, 6'h00, 8'h00, 1'b0);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);              // still past the end

      // k equal to n: the only subset is also the final one
      set_config(8, 8);
      queue_cmd(OP_RESTART, '0, '0, 1'b0);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);

      // illegal k values and an empty set all report exhausted
      set_config(0, 40);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);
      set_config(15, 64);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);
      set_config(2, 0);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);

      // oversized set_size saturates to the store depth
      set_config(1, 127);
      queue_cmd(OP_RESTART, '0, '0, 1'b0);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);
      queue_cmd(OP_NEXT, '0, '0, 1'b0);

      // random phases: mostly restart-then-next walks with loads mixed in; half of
      // them keep the old counters across the new setting
      for (ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin k = 8; n = 64; end
            1: begin k = 1; n = 1; end
            2: begin k = 8; n = 9; end
            default: begin
               if ($urandom_range(0, 3) != 0) begin
                  k = $urandom_range(1, 6);
                  n = $urandom_range(k, k + 5);
               end else begin
                  k = $urandom_range(0, 15);
                  n = $urandom_range(0, 127);
               end
            end
         endcase
         set_config(k, n);
         calm = (ph == 3 || ph == 6);
         if ($urandom_range(0, 1)) queue_cmd(OP_RESTART, '0, '0, 1'b0);
         for (i = 0; i < 17; i++) begin
            r = $urandom_range(0, 99);
            if (r < 8)
               queue_cmd(OP_RESTART, SLOT_W'($urandom_range(0, 63)),
                         ELEM_W'($urandom_range(0, 255)), 1'b0);
            else if (r < 20)
               queue_cmd(OP_LOAD, SLOT_W'($urandom_range(0, 63)),
                         ELEM_W'($urandom_range(0, 255)), 1'b0);
            else if (r < 24)
               queue_cmd(OP_UNUSED, SLOT_W'($urandom_range(0, 63)),
                         ELEM_W'($urandom_range(0, 255)), 1'b0);
            else
               // in one phase the sender pauses midway until all results are back
               queue_cmd(OP_NEXT, SLOT_W'($urandom_range(0, 63)),
                         ELEM_W'($urandom_range(0, 255)), ph == 4 && i == 14);
         end
      end

      settle();
      if (elem_expect.size() != 0) begin
         $display("%0t %0d expected rsp transactions never arrived", $time,
                  elem_expect.size());
         errors++;
      end
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/kce_pkg.sv
hdl/kce_ram.sv
hdl/kce_csr.sv
hdl/kce_seq.sv
hdl/k_combination_enumerator_unit.sv
bench/tb_k_combination_enumerator_unit.sv
